@@ src/dcsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Dual-channel safety relay package
// Command codes, option bits, step codes, register indexes and stream
// layout shared by the relay monitor and its checker.
// ----------------------------------------------------------------------------
package dcsr_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int IN_DATA_W   = 16;
	localparam int OUT_DATA_W  = 8;
	localparam int CMD_W       = 2;
	localparam int STEP_W      = 3;
	localparam int LIMIT_W     = 12;
	localparam int ERR_W       = 6;

	localparam logic [CMD_W-1:0] CMD_FAST_TICK   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SLOW_TICK   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR_CROSS = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE        = 2'd3;

	localparam int OPT_ENABLE       = 0;
	localparam int OPT_ANTIVALENT   = 1;
	localparam int OPT_ACK_REQUIRED = 2;
	localparam int OPT_EDGE_ACK     = 3;
	localparam int OPT_NO_HOLD      = 4;
	localparam int OPT_SKIP_00      = 5;
	localparam int OPT_CROSSCHECK   = 6;
	localparam int OPT_LOWLOW_OK    = 7;

	localparam logic [STEP_W-1:0] STEP_START     = 3'd0;
	localparam logic [STEP_W-1:0] STEP_WAIT_OPEN = 3'd1;
	localparam logic [STEP_W-1:0] STEP_OPEN      = 3'd2;
	localparam logic [STEP_W-1:0] STEP_PARTIAL   = 3'd3;
	localparam logic [STEP_W-1:0] STEP_SETTLE    = 3'd4;
	localparam logic [STEP_W-1:0] STEP_CLOSED    = 3'd5;

	localparam logic [CFG_INDEX_W-1:0] REG_OPTIONS1  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_OPTIONS2  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_START_DLY = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETTLE    = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ACK_HOLD  = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_XC_LIMIT  = 3'd5;

	localparam logic [7:0]         RST_START_DLY = 8'd20;
	localparam logic [7:0]         RST_SETTLE    = 8'd50;
	localparam logic [7:0]         RST_ACK_HOLD  = 8'd50;
	localparam logic [LIMIT_W-1:0] RST_XC_LIMIT  = 12'd3100;

	localparam logic [1:0] LINES_LOW  = 2'b00;
	localparam logic [1:0] LINES_HIGH = 2'b11;

	typedef struct packed {
		logic [1:0] ack_request;
		logic [3:0] selected_lines;
		logic [3:0] raw_lines;
		logic       parameters_complete;
		logic       system_fault;
	} in_item_t;

endpackage

@@ src/dual_channel_safety_relay.sv @@
// ----------------------------------------------------------------------------
// Dual-channel safety relay monitor
// Two safety circuits with step machines on the slow tick, a cross-circuit
// check on the fast tick, and sticky error flags.
// ----------------------------------------------------------------------------
//  Channel  | Group                    | Contents
//  ---------+--------------------------+--------------------------------------
//  input    | s_tvalid s_tready        | s_tuser command, s_tdata line fields
//  result   | m_tvalid m_tready        | m_tdata release and error flags
//  config   | cfg_we cfg_index         | cfg_data, one register per write
//
// Each transaction passes through the input register and then the result
// register, and one transaction can be accepted per cycle while the result
// is not stalled. The state update happens as a transaction leaves the
// input register. Reset clears the step, counter and flag state and loads
// the default register values. A stalled result holds the input register,
// which then drops s_tready.
module dual_channel_safety_relay #(
	parameter int CROSS_COUNT_WIDTH = 12,
	parameter int TICK_COUNT_WIDTH  = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// Bits: system_fault, parameters_complete, raw_lines[3:0],
	// selected_lines[3:0], ack_request1, ack_request2, zero fill.
	input  logic [dcsr_pkg::IN_DATA_W-1:0]    s_tdata,
	// Bits: command[1:0].
	input  logic [dcsr_pkg::CMD_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// Bits: release1, release2, cross_error1, cross_error2, start_error1,
	// start_error2, sequence_error1, sequence_error2.
	output logic [dcsr_pkg::OUT_DATA_W-1:0]   m_tdata,
	input  logic                              cfg_we,
	input  logic [dcsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [dcsr_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import dcsr_pkg::*;

	localparam int CW = CROSS_COUNT_WIDTH;
	localparam int TW = TICK_COUNT_WIDTH;

	logic [7:0]         opt_q [2];
	logic [7:0]         start_dly_q;
	logic [7:0]         settle_q;
	logic [7:0]         ack_hold_q;
	logic [LIMIT_W-1:0] limit_q;

	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	in_item_t           item_s1;
	logic               m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	logic [STEP_W-1:0]  step_q [2];
	logic [1:0]         closed_q;
	logic [1:0]         ack_flag_q;
	logic [1:0]         edge_pend_q;
	logic [1:0]         ackd_q;
	logic [TW-1:0]      hold_cnt_q [2];
	logic [TW-1:0]      settle_cnt_q [2];
	logic [CW-1:0]      cross_cnt_q [4];
	logic [TW-1:0]      start_cnt_q;
	logic [1:0]         rel_q;
	logic [ERR_W-1:0]   err_q;

	logic [STEP_W-1:0]  n_step [2];
	logic [1:0]         n_closed;
	logic [1:0]         n_ack_flag;
	logic [1:0]         n_edge_pend;
	logic [1:0]         n_ackd;
	logic [TW-1:0]      n_hold_cnt [2];
	logic [TW-1:0]      n_settle_cnt [2];
	logic [CW-1:0]      n_cross_cnt [4];
	logic [TW-1:0]      n_start_cnt;
	logic [1:0]         n_rel;
	logic [ERR_W-1:0]   n_err;

	logic               advance;

	function automatic logic [TW-1:0] tick_load(input logic [7:0] v);
		logic [TW+7:0] w;
		w = {{TW{1'b0}}, v};
		return w[TW-1:0];
	endfunction

	// Returns the trip flag above the updated counter.
	function automatic logic [CW:0] count_up(input logic [CW-1:0] cnt,
			input logic [LIMIT_W-1:0] lim);
		logic [CW+LIMIT_W-1:0] c_ext;
		logic [CW+LIMIT_W-1:0] l_ext;
		logic [CW-1:0]         n;
		c_ext = {{LIMIT_W{1'b0}}, cnt};
		l_ext = {{CW{1'b0}}, lim};
		n = cnt;
		if (c_ext < l_ext && cnt != {CW{1'b1}}) begin
			n = cnt + 1'b1;
		end
		c_ext = {{LIMIT_W{1'b0}}, n};
		return {c_ext >= l_ext, n};
	endfunction

	assign advance  = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_comb begin
		logic [7:0]    opt;
		logic [1:0]    pair;
		logic [1:0]    lines;
		logic          req;
		logic          trip;
		logic [CW:0]   cu;
		logic [1:0]    ia;
		logic [1:0]    ib;
		n_step       = step_q;
		n_closed     = closed_q;
		n_ack_flag   = ack_flag_q;
		n_edge_pend  = edge_pend_q;
		n_ackd       = ackd_q;
		n_hold_cnt   = hold_cnt_q;
		n_settle_cnt = settle_cnt_q;
		n_cross_cnt  = cross_cnt_q;
		n_start_cnt  = start_cnt_q;
		n_rel        = rel_q;
		n_err        = err_q;
		opt   = '0;
		pair  = '0;
		lines = '0;
		req   = 1'b0;
		trip  = 1'b0;
		cu    = '0;
		ia    = '0;
		ib    = '0;
		case (cmd_s1)
			CMD_FAST_TICK: begin
				for (int c = 0; c < 2; c++) begin
					opt  = opt_q[c];
					pair = item_s1.raw_lines[2*c +: 2];
					ia   = 2'(2 * c);
					ib   = 2'(2 * c + 1);
					trip = 1'b0;
					if (!opt[OPT_CROSSCHECK] || step_q[c] != STEP_CLOSED) begin
						n_cross_cnt[ia] = '0;
						n_cross_cnt[ib] = '0;
					end else if (pair == LINES_LOW) begin
						if (opt[OPT_LOWLOW_OK]) begin
							n_cross_cnt[ia] = '0;
							n_cross_cnt[ib] = '0;
						end
						cu = count_up(n_cross_cnt[ib], limit_q);
						n_cross_cnt[ib] = cu[CW-1:0];
						trip = cu[CW];
					end else begin
						if (pair[0]) begin
							cu = count_up(cross_cnt_q[ia], limit_q);
							n_cross_cnt[ia] = cu[CW-1:0];
							trip = trip | cu[CW];
						end else begin
							n_cross_cnt[ia] = '0;
						end
						if (pair[1]) begin
							cu = count_up(cross_cnt_q[ib], limit_q);
							n_cross_cnt[ib] = cu[CW-1:0];
							trip = trip | cu[CW];
						end else begin
							n_cross_cnt[ib] = '0;
						end
					end
					if (trip) begin
						n_step[c]       = STEP_WAIT_OPEN;
						n_closed[c]     = 1'b0;
						n_ack_flag[c]   = 1'b0;
						n_edge_pend[c]  = 1'b0;
						n_ackd[c]       = 1'b0;
						n_hold_cnt[c]   = '0;
						n_settle_cnt[c] = '0;
						n_err[c]        = 1'b1;
					end
				end
			end
			CMD_SLOW_TICK: begin
				if (item_s1.system_fault || !item_s1.parameters_complete) begin
					n_start_cnt = tick_load(start_dly_q);
					for (int c = 0; c < 2; c++) begin
						n_step[c]       = STEP_START;
						n_hold_cnt[c]   = '0;
						n_settle_cnt[c] = '0;
					end
					n_closed    = '0;
					n_ack_flag  = '0;
					n_edge_pend = '0;
					n_ackd      = '0;
					n_rel       = '0;
				end else if (start_cnt_q != '0) begin
					n_start_cnt = start_cnt_q - 1'b1;
				end else begin
					for (int c = 0; c < 2; c++) begin
						opt   = opt_q[c];
						lines = item_s1.selected_lines[2*c +: 2] ^
							{opt[OPT_ANTIVALENT], 1'b0};
						req   = item_s1.ack_request[c];
						if (opt[OPT_ENABLE]) begin
							if (hold_cnt_q[c] != '0) begin
								n_hold_cnt[c] = hold_cnt_q[c] - 1'b1;
							end else begin
								n_ack_flag[c] = 1'b0;
							end
							if (req) begin
								if (!opt[OPT_NO_HOLD]) begin
									n_hold_cnt[c] = tick_load(ack_hold_q);
								end
								if (!opt[OPT_EDGE_ACK]) begin
									n_ack_flag[c] = 1'b1;
								end else begin
									n_edge_pend[c] = 1'b1;
								end
							end else if (edge_pend_q[c]) begin
								n_ack_flag[c]  = 1'b1;
								n_edge_pend[c] = 1'b0;
							end
							if (!opt[OPT_ACK_REQUIRED]) begin
								n_ack_flag[c] = 1'b1;
							end
							if (ackd_q[c]) begin
								n_edge_pend[c] = 1'b0;
								n_ack_flag[c]  = 1'b0;
								n_hold_cnt[c]  = '0;
							end
							case (step_q[c])
								STEP_START: begin
									if (opt[OPT_SKIP_00]) begin
										if (lines == LINES_HIGH) begin
											n_closed[c] = 1'b1;
											n_step[c]   = STEP_CLOSED;
										end else begin
											n_step[c] = STEP_WAIT_OPEN;
										end
									end else if (lines == LINES_LOW) begin
										n_step[c] = STEP_WAIT_OPEN;
									end else begin
										n_err[2+c] = 1'b1;
									end
								end
								STEP_WAIT_OPEN: begin
									if (lines == LINES_LOW) begin
										n_step[c] = STEP_OPEN;
									end else if (lines == LINES_HIGH && !err_q[c]) begin
										n_err[4+c] = 1'b1;
									end
								end
								STEP_OPEN: begin
									if (lines == LINES_HIGH) begin
										n_settle_cnt[c] = tick_load(settle_q);
										n_closed[c]     = 1'b1;
										n_step[c]       = STEP_SETTLE;
									end else if (lines != LINES_LOW) begin
										n_closed[c] = 1'b0;
										n_step[c]   = STEP_PARTIAL;
									end
								end
								STEP_PARTIAL: begin
									if (lines == LINES_LOW) begin
										n_closed[c] = 1'b0;
										n_step[c]   = STEP_WAIT_OPEN;
									end else if (lines == LINES_HIGH) begin
										n_closed[c]     = 1'b1;
										n_settle_cnt[c] = tick_load(settle_q);
										n_step[c]       = STEP_SETTLE;
									end
								end
								STEP_SETTLE: begin
									if (settle_cnt_q[c] != '0) begin
										n_settle_cnt[c] = settle_cnt_q[c] - 1'b1;
										if (lines == LINES_LOW) begin
											n_closed[c] = 1'b0;
											n_step[c]   = STEP_WAIT_OPEN;
										end
									end else if (lines == LINES_HIGH) begin
										n_closed[c] = 1'b1;
										n_step[c]   = STEP_CLOSED;
									end else begin
										n_closed[c] = 1'b0;
										n_step[c]   = STEP_WAIT_OPEN;
									end
								end
								STEP_CLOSED: begin
									if (lines == LINES_HIGH) begin
										n_closed[c] = 1'b1;
									end else begin
										n_closed[c] = 1'b0;
										n_step[c]   = STEP_WAIT_OPEN;
									end
								end
								default: begin
								end
							endcase
							if (!n_closed[c]) begin
								n_ackd[c] = 1'b0;
							end
							if (n_closed[c] && n_ack_flag[c]) begin
								n_ackd[c] = 1'b1;
							end
							n_rel[c] = n_ackd[c];
						end
					end
				end
			end
			CMD_CLEAR_CROSS: begin
				for (int i = 0; i < 4; i++) begin
					n_cross_cnt[i] = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opt_q[0]    <= '0;
			opt_q[1]    <= '0;
			start_dly_q <= RST_START_DLY;
			settle_q    <= RST_SETTLE;
			ack_hold_q  <= RST_ACK_HOLD;
			limit_q     <= RST_XC_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_OPTIONS1:  opt_q[0]    <= cfg_data[7:0];
				REG_OPTIONS2:  opt_q[1]    <= cfg_data[7:0];
				REG_START_DLY: start_dly_q <= cfg_data[7:0];
				REG_SETTLE:    settle_q    <= cfg_data[7:0];
				REG_ACK_HOLD:  ack_hold_q  <= cfg_data[7:0];
				REG_XC_LIMIT:  limit_q     <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1  <= s_tuser;
			item_s1 <= s_tdata[$bits(in_item_t)-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_tdata_q <= {n_err, n_rel};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				step_q[c]       <= STEP_START;
				hold_cnt_q[c]   <= '0;
				settle_cnt_q[c] <= '0;
			end
			for (int i = 0; i < 4; i++) begin
				cross_cnt_q[i] <= '0;
			end
			closed_q    <= '0;
			ack_flag_q  <= '0;
			edge_pend_q <= '0;
			ackd_q      <= '0;
			start_cnt_q <= '0;
			rel_q       <= '0;
			err_q       <= '0;
		end else if (advance) begin
			step_q       <= n_step;
			hold_cnt_q   <= n_hold_cnt;
			settle_cnt_q <= n_settle_cnt;
			cross_cnt_q  <= n_cross_cnt;
			closed_q     <= n_closed;
			ack_flag_q   <= n_ack_flag;
			edge_pend_q  <= n_edge_pend;
			ackd_q       <= n_ackd;
			start_cnt_q  <= n_start_cnt;
			rel_q        <= n_rel;
			err_q        <= n_err;
		end
	end

endmodule

@@ src/dcsr_checker.sv @@
// ----------------------------------------------------------------------------
// Dual-channel safety relay port checker
// Watches the stream ports of the relay monitor for stalled result stability,
// occupancy and sticky error behavior.
// ----------------------------------------------------------------------------
module dcsr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [dcsr_pkg::OUT_DATA_W-1:0]  m_tdata
);
	import dcsr_pkg::*;

	logic [1:0]       pending_q;
	logic [ERR_W-1:0] seen_err_q;
	logic             in_acc;
	logic             out_acc;

	assign in_acc  = s_tvalid && s_tready;
	assign out_acc = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= '0;
			seen_err_q <= '0;
		end else begin
			pending_q <= pending_q + {1'b0, in_acc} - {1'b0, out_acc};
			if (out_acc) begin
				seen_err_q <= m_tdata[OUT_DATA_W-1:2];
			end
		end
	end

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("Stalled result changed or was dropped.");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("More than two transactions in flight.");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("Result shown without an accepted transaction.");

	a_errors_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (m_tdata[OUT_DATA_W-1:2] & seen_err_q) == seen_err_q)
		else $error("A sticky error flag cleared.");

endmodule

bind dual_channel_safety_relay dcsr_checker u_dcsr_checker (.*);

@@ tb/dual_channel_safety_relay_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dual-channel safety relay monitor testbench
// Drives slow ticks, fast ticks and clear commands through the input stream
// under several register settings and random handshake gaps. A scoreboard
// predicts the release and error flags of every transaction and compares
// them with each result that leaves the block.
// ----------------------------------------------------------------------------
module dual_channel_safety_relay_tb;
	import dcsr_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 66;
	localparam int LONG_STALL      = 60;

	class relay_scoreboard;
		bit [7:0]  opt [2];
		bit [7:0]  start_dly, settle_len, hold_len;
		bit [11:0] xc_limit;
		bit [2:0]  phase [2];
		bit        closed [2], ack_ok [2], fall_wait [2], latched [2];
		bit [7:0]  hold_left [2], settle_left [2];
		bit [11:0] xc_cnt [4];
		bit [7:0]  dly_left;
		bit [1:0]  release_q;
		bit [5:0]  err_q;
		bit [7:0]  flags_due [$];
		int        err_count, checked, released_seen;
		string     field_label [8];

		function new();
			field_label = '{"release1", "release2", "cross_error1", "cross_error2",
				"start_error1", "start_error2", "sequence_error1", "sequence_error2"};
			opt[0] = 8'h00;
			opt[1] = 8'h00;
			start_dly = RST_START_DLY;
			settle_len = RST_SETTLE;
			hold_len = RST_ACK_HOLD;
			xc_limit = RST_XC_LIMIT;
			drop_circuit(0);
			drop_circuit(1);
			for (int i = 0; i < 4; i++)
				xc_cnt[i] = '0;
			dly_left = '0;
			release_q = '0;
			err_q = '0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_OPTIONS1:  opt[0] = value[7:0];
				REG_OPTIONS2:  opt[1] = value[7:0];
				REG_START_DLY: start_dly = value[7:0];
				REG_SETTLE:    settle_len = value[7:0];
				REG_ACK_HOLD:  hold_len = value[7:0];
				REG_XC_LIMIT:  xc_limit = value[LIMIT_W-1:0];
				default: ;
			endcase
		endfunction

		function void drop_circuit(int c);
			phase[c] = STEP_START;
			closed[c] = 1'b0;
			ack_ok[c] = 1'b0;
			fall_wait[c] = 1'b0;
			latched[c] = 1'b0;
			hold_left[c] = '0;
			settle_left[c] = '0;
		endfunction

		function bit bump(int i);
			if (xc_cnt[i] < xc_limit && xc_cnt[i] != 12'hFFF)
				xc_cnt[i]++;
			return xc_cnt[i] >= xc_limit;
		endfunction

		function void cross_check(int c, bit [3:0] raw);
			bit [1:0] pair;
			bit       trip;
			pair = raw[2*c +: 2];
			trip = 1'b0;
			if (!opt[c][OPT_CROSSCHECK] || phase[c] != STEP_CLOSED) begin
				xc_cnt[2*c] = '0;
				xc_cnt[2*c+1] = '0;
				return;
			end
			if (pair == LINES_LOW) begin
				if (opt[c][OPT_LOWLOW_OK]) begin
					xc_cnt[2*c] = '0;
					xc_cnt[2*c+1] = '0;
				end
				trip = bump(2*c+1);
			end else begin
				if (pair[0]) begin
					if (bump(2*c))
						trip = 1'b1;
				end else begin
					xc_cnt[2*c] = '0;
				end
				if (pair[1]) begin
					if (bump(2*c+1))
						trip = 1'b1;
				end else begin
					xc_cnt[2*c+1] = '0;
				end
			end
			if (trip) begin
				drop_circuit(c);
				phase[c] = STEP_WAIT_OPEN;
				err_q[c] = 1'b1;
			end
		endfunction

		function void evaluate(int c, bit [3:0] sel, bit req);
			bit [7:0] o;
			bit [1:0] ln;
			o = opt[c];
			ln = sel[2*c +: 2];
			if (!o[OPT_ENABLE])
				return;
			if (o[OPT_ANTIVALENT])
				ln ^= 2'b10;

			if (hold_left[c] != 0)
				hold_left[c]--;
			else
				ack_ok[c] = 1'b0;
			if (req) begin
				if (!o[OPT_NO_HOLD])
					hold_left[c] = hold_len;
				if (!o[OPT_EDGE_ACK])
					ack_ok[c] = 1'b1;
				else
					fall_wait[c] = 1'b1;
			end else if (fall_wait[c]) begin
				ack_ok[c] = 1'b1;
				fall_wait[c] = 1'b0;
			end
			if (!o[OPT_ACK_REQUIRED])
				ack_ok[c] = 1'b1;
			if (latched[c]) begin
				fall_wait[c] = 1'b0;
				ack_ok[c] = 1'b0;
				hold_left[c] = '0;
			end

			case (phase[c])
				STEP_START: begin
					if (o[OPT_SKIP_00]) begin
						if (ln == LINES_HIGH) begin
							closed[c] = 1'b1;
							phase[c] = STEP_CLOSED;
						end else begin
							phase[c] = STEP_WAIT_OPEN;
						end
					end else if (ln == LINES_LOW) begin
						phase[c] = STEP_WAIT_OPEN;
					end else begin
						err_q[2+c] = 1'b1;
					end
				end
				STEP_WAIT_OPEN: begin
					if (ln == LINES_LOW)
						phase[c] = STEP_OPEN;
					else if (ln == LINES_HIGH && !err_q[c])
						err_q[4+c] = 1'b1;
				end
				STEP_OPEN: begin
					if (ln == LINES_HIGH) begin
						settle_left[c] = settle_len;
						closed[c] = 1'b1;
						phase[c] = STEP_SETTLE;
					end else if (ln != LINES_LOW) begin
						closed[c] = 1'b0;
						phase[c] = STEP_PARTIAL;
					end
				end
				STEP_PARTIAL: begin
					if (ln == LINES_LOW) begin
						closed[c] = 1'b0;
						phase[c] = STEP_WAIT_OPEN;
					end else if (ln == LINES_HIGH) begin
						closed[c] = 1'b1;
						settle_left[c] = settle_len;
						phase[c] = STEP_SETTLE;
					end
				end
				STEP_SETTLE: begin
					if (settle_left[c] != 0) begin
						settle_left[c]--;
						if (ln == LINES_LOW) begin
							closed[c] = 1'b0;
							phase[c] = STEP_WAIT_OPEN;
						end
					end else if (ln == LINES_HIGH) begin
						closed[c] = 1'b1;
						phase[c] = STEP_CLOSED;
					end else begin
						closed[c] = 1'b0;
						phase[c] = STEP_WAIT_OPEN;
					end
				end
				STEP_CLOSED: begin
					if (ln == LINES_HIGH) begin
						closed[c] = 1'b1;
					end else begin
						closed[c] = 1'b0;
						phase[c] = STEP_WAIT_OPEN;
					end
				end
				default: ;
			endcase

			if (!closed[c])
				latched[c] = 1'b0;
			if (closed[c] && ack_ok[c])
				latched[c] = 1'b1;
			release_q[c] = latched[c];
		endfunction

		function void note_input(logic [CMD_W-1:0] cmd, in_item_t item);
			case (cmd)
				CMD_FAST_TICK: begin
					cross_check(0, item.raw_lines);
					cross_check(1, item.raw_lines);
				end
				CMD_SLOW_TICK: begin
					if (item.system_fault || !item.parameters_complete) begin
						dly_left = start_dly;
						drop_circuit(0);
						drop_circuit(1);
						release_q = '0;
					end else if (dly_left != 0) begin
						dly_left--;
					end else begin
						evaluate(0, item.selected_lines, item.ack_request[0]);
						evaluate(1, item.selected_lines, item.ack_request[1]);
					end
				end
				CMD_CLEAR_CROSS: begin
					for (int i = 0; i < 4; i++)
						xc_cnt[i] = '0;
				end
				default: ;
			endcase
			flags_due.push_back({err_q, release_q});
		endfunction

		task report(string msg);
			err_count++;
			if (err_count <= 100)
				$display("MISMATCH: %s", msg);
		endtask

		task check_result(logic [OUT_DATA_W-1:0] got);
			bit [7:0] want;
			if (flags_due.size() == 0) begin
				report($sformatf("result 0x%02h arrived with no transaction outstanding", got));
				return;
			end
			want = flags_due.pop_front();
			checked++;
			for (int i = 0; i < 8; i++)
				if (got[i] !== want[i])
					report($sformatf("result %0d: %s is %b, expected %b",
						checked, field_label[i], got[i], want[i]));
			if (want[1:0] != 2'b00)
				released_seen++;
		endtask
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic [CMD_W-1:0]       s_tuser = CMD_NONE;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	relay_scoreboard board;
	bit              no_idle = 1'b0;
	bit [1:0]        line_goal [2];
	int              cmd_count [4];
	int              received = 0;
	int              settings_run = 0;

	dual_channel_safety_relay dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		board.set_reg(idx, value);
	endtask

	task automatic configure(input bit [7:0] opt1, opt2, input logic [CFG_DATA_W-1:0] dly,
		settle, hold, input bit [11:0] limit);
		write_reg(REG_OPTIONS1, CFG_DATA_W'(opt1));
		write_reg(REG_OPTIONS2, CFG_DATA_W'(opt2));
		write_reg(REG_START_DLY, dly);
		write_reg(REG_SETTLE, settle);
		write_reg(REG_ACK_HOLD, hold);
		write_reg(REG_XC_LIMIT, limit);
		cfg_we <= 1'b0;
		settings_run++;
	endtask

	task automatic send_item(input logic [CMD_W-1:0] cmd, input in_item_t item);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {{(IN_DATA_W - $bits(in_item_t)){1'b0}}, item};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_input(cmd, item);
		cmd_count[cmd]++;
	endtask

	task automatic send_fields(input logic [CMD_W-1:0] cmd, input bit fault, complete,
		input bit [3:0] raw, sel, input bit [1:0] req);
		in_item_t item;
		item.system_fault = fault;
		item.parameters_complete = complete;
		item.raw_lines = raw;
		item.selected_lines = sel;
		item.ack_request = req;
		send_item(cmd, item);
	endtask

	function automatic bit [7:0] draw_options();
		bit [7:0] o;
		o = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 5) != 0)
			o[OPT_ENABLE] = 1'b1;
		return o;
	endfunction

	task automatic send_random();
		in_item_t         item;
		logic [CMD_W-1:0] cmd;
		int               pick;
		bit [1:0]         pair;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			cmd = CMD_SLOW_TICK;
		else if (pick < 90)
			cmd = CMD_FAST_TICK;
		else if (pick < 95)
			cmd = CMD_CLEAR_CROSS;
		else
			cmd = CMD_NONE;
		item.system_fault = ($urandom_range(0, 49) == 0);
		item.parameters_complete = ($urandom_range(0, 49) != 0);
		for (int c = 0; c < 2; c++) begin
			if ($urandom_range(0, 9) == 0)
				line_goal[c] = ~line_goal[c];
			if ($urandom_range(0, 9) == 0)
				pair = 2'($urandom_range(0, 3));
			else
				pair = line_goal[c];
			if (board.opt[c][OPT_ANTIVALENT])
				pair ^= 2'b10;
			item.selected_lines[2*c +: 2] = pair;
		end
		if ($urandom_range(0, 1) == 0)
			item.raw_lines = item.selected_lines;
		else
			item.raw_lines = 4'($urandom_range(0, 15));
		item.ack_request[0] = ($urandom_range(0, 3) == 0);
		item.ack_request[1] = ($urandom_range(0, 3) == 0);
		send_item(cmd, item);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (board.flags_due.size() != 0)
			@(posedge clk);
	endtask

	initial begin : result_sink
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 3);
			if (received == 100 || received == 350)
				stall = LONG_STALL;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			board.check_result(m_tdata);
			received++;
		end
	end

	initial begin : watchdog
		int cycles;
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding",
			cycles, board.flags_due.size());
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		configure(8'h45, 8'hEB, 12'd1, 12'hF01, 12'd2, 12'd2);
		send_fields(CMD_NONE, 1, 1, 4'hF, 4'hF, 2'b11);
		send_fields(CMD_SLOW_TICK, 1, 1, 4'h0, 4'h0, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 0, 4'h0, 4'h0, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'h0, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0101, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0000, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0111, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b1000, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0111, 2'b01);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0111, 2'b10);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'h0, 4'b0111, 2'b00);
		send_fields(CMD_FAST_TICK, 0, 1, 4'b0000, 4'b0111, 2'b00);
		send_fields(CMD_FAST_TICK, 0, 1, 4'b1101, 4'b0111, 2'b00);
		send_fields(CMD_CLEAR_CROSS, 0, 1, 4'h0, 4'h0, 2'b00);
		send_fields(CMD_FAST_TICK, 0, 1, 4'b0010, 4'b0111, 2'b00);
		send_fields(CMD_FAST_TICK, 0, 1, 4'b0011, 4'b0111, 2'b00);
		send_fields(CMD_SLOW_TICK, 0, 1, 4'hF, 4'hF, 2'b11);
		send_fields(CMD_NONE, 0, 0, 4'h0, 4'h0, 2'b00);
		send_fields(CMD_FAST_TICK, 1, 0, 4'hF, 4'hF, 2'b11);
		send_fields(CMD_SLOW_TICK, 1, 0, 4'hF, 4'hF, 2'b11);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(8'hFF, 8'hFF, 12'd255, 12'd255, 12'd255, 12'd4095);
				1: configure(8'h00, draw_options() | 8'h41, 12'd0, 12'd0, 12'd0, 12'd0);
				default: configure(draw_options(), draw_options(),
					CFG_DATA_W'($urandom_range(0, 3)), CFG_DATA_W'($urandom_range(0, 6)),
					CFG_DATA_W'($urandom_range(0, 8)), 12'($urandom_range(1, 24)));
			endcase
			no_idle = (p % 3 == 2);
			repeat (ITEMS_PER_PHASE)
				send_random();
			drain();
		end
		no_idle = 1'b0;

		repeat (8) @(posedge clk);
		$display("Summary: %0d transactions (%0d slow ticks, %0d fast ticks, %0d clears, %0d unused)",
			cmd_count[CMD_SLOW_TICK] + cmd_count[CMD_FAST_TICK] + cmd_count[CMD_CLEAR_CROSS]
			+ cmd_count[CMD_NONE], cmd_count[CMD_SLOW_TICK], cmd_count[CMD_FAST_TICK],
			cmd_count[CMD_CLEAR_CROSS], cmd_count[CMD_NONE]);
		$display("Summary: %0d results checked under %0d register settings, %0d with a release",
			board.checked, settings_run, board.released_seen);
		if (board.err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
